FILE: hdl/kruskal_maze_union_find_assert.svh
// assertion macros shared by the maze carving rtl
// expects clk and rst_n in the scope of each use
`ifndef KRUSKAL_MAZE_UNION_FIND_ASSERT_SVH
`define KRUSKAL_MAZE_UNION_FIND_ASSERT_SVH

// same-cycle implication
`define KMUF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KMUF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/kmuf_pkg.sv
// types, codes and sizes for the maze carving block
// no dependencies
package kmuf_pkg;

    localparam int MAX_WIDTH   = 32;
    localparam int MAX_HEIGHT  = 32;
    localparam int CELL_COUNT  = MAX_WIDTH * MAX_HEIGHT;
    localparam int CELL_W      = $clog2(CELL_COUNT);
    localparam int CFG_W       = 6;
    localparam int COORD_W     = 5;
    localparam int WALLS_W     = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] FUNC_CARVE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    localparam logic [WALLS_W-1:0] WALL_N = 4'b0001;
    localparam logic [WALLS_W-1:0] WALL_S = 4'b0010;
    localparam logic [WALLS_W-1:0] WALL_E = 4'b0100;
    localparam logic [WALLS_W-1:0] WALL_W = 4'b1000;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_CARVE,
        KIND_READ,
        KIND_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic              bad;
        logic              west;
        logic [CELL_W-1:0] cell_addr;
        logic [CELL_W-1:0] nbr;
    } cmd_t;

    typedef struct packed {
        logic empty;
        cmd_t cmd;
    } cmd_head_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_WALK_C,
        ST_WALK_N,
        ST_MASK_C,
        ST_MASK_N,
        ST_READ
    } back_state_t;

endpackage

FILE: hdl/kruskal_maze_union_find.sv
// top level of the kruskal maze carving block
// depends on kmuf_pkg, kmuf_front and kmuf_back
//
// channel   handshake             payload
// input     push / full           func, cell_x, cell_y, toward_west
// result    empty / pop           carved, bad_edge, cell_walls, neighbour_walls
// config    cfg_we                cfg_index, cfg_data
//
// a carve walks up from the cell and from its neighbour: one parent read per tree level
// a clear sweeps both stores again before it gives its result
// after reset both stores are swept with full held high
// the back part takes the next command only once the result register is empty
// commands queue two deep ahead of the back part, so input is taken while a result waits
module kruskal_maze_union_find (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [kmuf_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    func,
    input  logic [kmuf_pkg::COORD_W-1:0]  cell_x,
    input  logic [kmuf_pkg::COORD_W-1:0]  cell_y,
    input  logic                          toward_west,
    output logic                          empty,
    input  logic                          pop,
    output logic                          carved,
    output logic                          bad_edge,
    output logic [kmuf_pkg::WALLS_W-1:0]  cell_walls,
    output logic [kmuf_pkg::WALLS_W-1:0]  neighbour_walls
);
    import kmuf_pkg::*;

    cmd_head_t cmd_head;
    logic      cmd_pop;
    logic      init_busy;

    kmuf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .func        (func),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .toward_west (toward_west),
        .init_busy   (init_busy),
        .cmd_pop     (cmd_pop),
        .cmd_head    (cmd_head),
        .full        (full)
    );

    kmuf_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_head        (cmd_head),
        .cmd_pop         (cmd_pop),
        .init_busy       (init_busy),
        .pop             (pop),
        .empty           (empty),
        .carved          (carved),
        .bad_edge        (bad_edge),
        .cell_walls      (cell_walls),
        .neighbour_walls (neighbour_walls)
    );

endmodule

FILE: hdl/kmuf_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module kmuf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/kmuf_queue.sv
// short command queue between the front and back parts
// depends on kmuf_pkg and the assertion macro header
`include "kruskal_maze_union_find_assert.svh"
module kmuf_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  kmuf_pkg::cmd_t    cmd_in,
    input  logic              pop,
    output kmuf_pkg::cmd_head_t head,
    output logic              full
);
    import kmuf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign head.empty = (count_reg == '0);
    assign head.cmd   = entries_reg[rd_ptr_reg];
    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));

    `KMUF_ASSERT_IMPL(a_no_overflow, push, !full || pop, "push into a full command queue")
    `KMUF_ASSERT_IMPL(a_no_underflow, pop, !head.empty, "pop from an empty command queue")

endmodule

FILE: hdl/kmuf_front.sv
// front part: grid size registers, edge classification and command queue
// depends on kmuf_pkg and kmuf_queue
module kmuf_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [kmuf_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          push,
    input  logic [1:0]                    func,
    input  logic [kmuf_pkg::COORD_W-1:0]  cell_x,
    input  logic [kmuf_pkg::COORD_W-1:0]  cell_y,
    input  logic                          toward_west,
    input  logic                          init_busy,
    input  logic                          cmd_pop,
    output kmuf_pkg::cmd_head_t           cmd_head,
    output logic                          full
);
    import kmuf_pkg::*;

    logic [CFG_W-1:0]  grid_width_reg;
    logic [CFG_W-1:0]  grid_height_reg;
    logic [CFG_W-1:0]  eff_w;
    logic [CFG_W-1:0]  eff_h;
    logic              in_grid;
    logic              edge_bad;
    logic [CELL_W-1:0] cell_idx;
    cmd_t              cmd;
    logic              q_full;
    logic              q_push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= CFG_W'(32);
            grid_height_reg <= CFG_W'(32);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default:         grid_width_reg  <= grid_width_reg;
            endcase
        end
    end

    always_comb
    begin
        eff_w    = (grid_width_reg > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : grid_width_reg;
        eff_h    = (grid_height_reg > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : grid_height_reg;
        in_grid  = (CFG_W'(cell_x) < eff_w) && (CFG_W'(cell_y) < eff_h);
        edge_bad = !in_grid || (toward_west ? (cell_x == '0) : (cell_y == '0));
        cell_idx = CELL_W'(CELL_W'(cell_y) * CELL_W'(MAX_WIDTH)) + CELL_W'(cell_x);

        cmd.west      = toward_west;
        cmd.cell_addr = cell_idx;
        cmd.nbr       = toward_west ? (cell_idx - 1'b1) : (cell_idx - CELL_W'(MAX_WIDTH));
        cmd.bad       = 1'b0;
        cmd.kind      = KIND_ZERO;
        case (func)
            FUNC_CARVE:
            begin
                cmd.bad  = edge_bad;
                cmd.kind = edge_bad ? KIND_ZERO : KIND_CARVE;
            end
            FUNC_READ:
            begin
                cmd.bad  = !in_grid;
                cmd.kind = in_grid ? KIND_READ : KIND_ZERO;
            end
            FUNC_CLEAR:
            begin
                cmd.kind = KIND_CLEAR;
            end
            default:
            begin
                cmd.kind = KIND_ZERO;
            end
        endcase
    end

    assign full   = q_full || init_busy;
    assign q_push = push && !full;

    kmuf_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .cmd_in (cmd),
        .pop    (cmd_pop),
        .head   (cmd_head),
        .full   (q_full)
    );

endmodule

FILE: hdl/kmuf_back.sv
// back part: root walks, linking, passage updates, store sweep, result slot
// depends on kmuf_pkg, kmuf_ram and the assertion macro header
`include "kruskal_maze_union_find_assert.svh"
module kmuf_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kmuf_pkg::cmd_head_t           cmd_head,
    output logic                          cmd_pop,
    output logic                          init_busy,
    input  logic                          pop,
    output logic                          empty,
    output logic                          carved,
    output logic                          bad_edge,
    output logic [kmuf_pkg::WALLS_W-1:0]  cell_walls,
    output logic [kmuf_pkg::WALLS_W-1:0]  neighbour_walls
);
    import kmuf_pkg::*;

    back_state_t       state_reg;
    back_state_t       state_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic [CELL_W-1:0] cur_reg;
    logic [CELL_W-1:0] cur_next;
    logic [CELL_W-1:0] root_c_reg;
    logic [CELL_W-1:0] root_c_next;
    logic              carved_reg;
    logic              carved_next;
    logic [WALLS_W-1:0] cw_reg;
    logic [WALLS_W-1:0] cw_next;
    logic [CELL_W-1:0] sweep_reg;
    logic [CELL_W-1:0] sweep_next;
    logic              reply_reg;
    logic              reply_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_carved_reg;
    logic               out_bad_reg;
    logic [WALLS_W-1:0] out_cw_reg;
    logic [WALLS_W-1:0] out_nw_reg;

    logic               produce;
    logic               res_carved;
    logic               res_bad;
    logic [WALLS_W-1:0] res_cw;
    logic [WALLS_W-1:0] res_nw;

    logic               p_we;
    logic [CELL_W-1:0]  p_waddr;
    logic [CELL_W-1:0]  p_wdata;
    logic [CELL_W-1:0]  p_raddr;
    logic [CELL_W-1:0]  p_rdata;
    logic               m_we;
    logic [CELL_W-1:0]  m_waddr;
    logic [WALLS_W-1:0] m_wdata;
    logic [CELL_W-1:0]  m_raddr;
    logic [WALLS_W-1:0] m_rdata;

    logic               at_root;
    logic               last_sweep;
    logic               take;
    logic [WALLS_W-1:0] cell_bit;
    logic [WALLS_W-1:0] nbr_bit;
    logic [WALLS_W-1:0] mask_new;

    assign at_root    = (p_rdata == cur_reg);
    assign last_sweep = (sweep_reg == CELL_W'(CELL_COUNT - 1));
    assign take       = !cmd_head.empty && !out_valid_reg;
    assign cell_bit   = cmd_reg.west ? WALL_W : WALL_N;
    assign nbr_bit    = cmd_reg.west ? WALL_E : WALL_S;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP:
            begin
                if (last_sweep)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    case (cmd_head.cmd.kind)
                        KIND_CARVE: state_next = ST_WALK_C;
                        KIND_READ:  state_next = ST_READ;
                        KIND_CLEAR: state_next = ST_SWEEP;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WALK_C:
            begin
                if (at_root)
                begin
                    state_next = ST_WALK_N;
                end
            end
            ST_WALK_N:
            begin
                if (at_root)
                begin
                    state_next = ST_MASK_C;
                end
            end
            ST_MASK_C: state_next = ST_MASK_N;
            ST_MASK_N: state_next = ST_IDLE;
            ST_READ:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and store controls
    always_comb
    begin
        cmd_pop     = 1'b0;
        cmd_next    = cmd_reg;
        cur_next    = cur_reg;
        root_c_next = root_c_reg;
        carved_next = carved_reg;
        cw_next     = cw_reg;
        sweep_next  = sweep_reg;
        reply_next  = reply_reg;
        produce     = 1'b0;
        res_carved  = 1'b0;
        res_bad     = 1'b0;
        res_cw      = '0;
        res_nw      = '0;
        mask_new    = m_rdata;
        p_we        = 1'b0;
        p_waddr     = sweep_reg;
        p_wdata     = sweep_reg;
        p_raddr     = cur_reg;
        m_we        = 1'b0;
        m_waddr     = sweep_reg;
        m_wdata     = '0;
        m_raddr     = cmd_reg.cell_addr;
        case (state_reg)
            ST_SWEEP:
            begin
                p_we       = 1'b1;
                m_we       = 1'b1;
                sweep_next = last_sweep ? '0 : sweep_reg + 1'b1;
                if (last_sweep)
                begin
                    produce    = reply_reg;
                    reply_next = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    cmd_pop     = 1'b1;
                    cmd_next    = cmd_head.cmd;
                    cur_next    = cmd_head.cmd.cell_addr;
                    p_raddr     = cmd_head.cmd.cell_addr;
                    m_raddr     = cmd_head.cmd.cell_addr;
                    carved_next = 1'b0;
                    case (cmd_head.cmd.kind)
                        KIND_ZERO:
                        begin
                            produce = 1'b1;
                            res_bad = cmd_head.cmd.bad;
                        end
                        KIND_CLEAR:
                        begin
                            reply_next = 1'b1;
                            sweep_next = '0;
                        end
                        default:
                        begin
                            produce = 1'b0;
                        end
                    endcase
                end
            end
            ST_WALK_C:
            begin
                if (at_root)
                begin
                    root_c_next = cur_reg;
                    cur_next    = cmd_reg.nbr;
                    p_raddr     = cmd_reg.nbr;
                end
                else
                begin
                    cur_next = p_rdata;
                    p_raddr  = p_rdata;
                end
            end
            ST_WALK_N:
            begin
                if (at_root)
                begin
                    // hang the neighbour's root under the cell itself
                    carved_next = (cur_reg != root_c_reg);
                    p_we        = (cur_reg != root_c_reg);
                    p_waddr     = cur_reg;
                    p_wdata     = cmd_reg.cell_addr;
                    m_raddr     = cmd_reg.cell_addr;
                end
                else
                begin
                    cur_next = p_rdata;
                    p_raddr  = p_rdata;
                end
            end
            ST_MASK_C:
            begin
                mask_new = m_rdata | (carved_reg ? cell_bit : '0);
                m_we     = carved_reg;
                m_waddr  = cmd_reg.cell_addr;
                m_wdata  = mask_new;
                cw_next  = ~mask_new;
                m_raddr  = cmd_reg.nbr;
            end
            ST_MASK_N:
            begin
                mask_new   = m_rdata | (carved_reg ? nbr_bit : '0);
                m_we       = carved_reg;
                m_waddr    = cmd_reg.nbr;
                m_wdata    = mask_new;
                produce    = 1'b1;
                res_carved = carved_reg;
                res_cw     = cw_reg;
                res_nw     = ~mask_new;
            end
            ST_READ:
            begin
                produce = 1'b1;
                res_cw  = ~m_rdata;
            end
            default:
            begin
                produce = 1'b0;
            end
        endcase
        out_valid_next = produce || (out_valid_reg && !pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_reg     <= '0;
            reply_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            reply_reg     <= reply_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        cur_reg    <= cur_next;
        root_c_reg <= root_c_next;
        carved_reg <= carved_next;
        cw_reg     <= cw_next;
        if (produce)
        begin
            out_carved_reg <= res_carved;
            out_bad_reg    <= res_bad;
            out_cw_reg     <= res_cw;
            out_nw_reg     <= res_nw;
        end
    end

    kmuf_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_parent_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    kmuf_ram #(
        .WIDTH (WALLS_W),
        .DEPTH (CELL_COUNT)
    ) u_passage_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    assign init_busy       = (state_reg == ST_SWEEP) && !reply_reg;
    assign empty           = !out_valid_reg;
    assign carved          = out_carved_reg;
    assign bad_edge        = out_bad_reg;
    assign cell_walls      = out_cw_reg;
    assign neighbour_walls = out_nw_reg;

    `KMUF_ASSERT_IMPL(a_slot_free, produce, !out_valid_reg, "result produced over a waiting result")
    `KMUF_ASSERT_IMPL(a_no_take_in_sweep, state_reg == ST_SWEEP, !cmd_pop, "command taken during store sweep")
    `KMUF_ASSERT_NEXT(a_sweep_steps, (state_reg == ST_SWEEP) && !last_sweep, (state_reg == ST_SWEEP) && (sweep_reg == $past(sweep_reg) + 1'b1), "store sweep skipped an entry")

endmodule

FILE: bench/tb_kruskal_maze_union_find.sv
// testbench for kruskal_maze_union_find: directed and random carve, read and clear traffic
// predicts every result from its own union-find and passage model and checks each transfer
// depends on kmuf_pkg and kruskal_maze_union_find
module tb_kruskal_maze_union_find;
    timeunit 1ns;
    timeprecision 1ps;

    import kmuf_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_REPORTED = 10;
    localparam int HOLD_AFTER = 200;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        logic [1:0]         func;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               west;
    } maze_cmd_t;

    typedef struct packed {
        logic               carved;
        logic               bad;
        logic [WALLS_W-1:0] cell_walls;
        logic [WALLS_W-1:0] nbr_walls;
    } wall_report_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic                 cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 push;
    logic                 full;
    logic [1:0]           func;
    logic [COORD_W-1:0]   cell_x;
    logic [COORD_W-1:0]   cell_y;
    logic                 toward_west;
    logic                 empty;
    logic                 pop;
    logic                 carved;
    logic                 bad_edge;
    logic [WALLS_W-1:0]   cell_walls;
    logic [WALLS_W-1:0]   neighbour_walls;

    kruskal_maze_union_find dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .push            (push),
        .full            (full),
        .func            (func),
        .cell_x          (cell_x),
        .cell_y          (cell_y),
        .toward_west     (toward_west),
        .empty           (empty),
        .pop             (pop),
        .carved          (carved),
        .bad_edge        (bad_edge),
        .cell_walls      (cell_walls),
        .neighbour_walls (neighbour_walls)
    );

    // maze model
    int               parent_of [CELL_COUNT];
    logic [WALLS_W-1:0] open_mask [CELL_COUNT];
    logic [CFG_W-1:0] grid_w;
    logic [CFG_W-1:0] grid_h;

    maze_cmd_t    cmd_backlog [$];
    wall_report_t report_queue [$];

    bit in_accepted;
    int results_seen;
    int mismatch_count;
    int idle_cycles;
    int burst_left;
    int gap_left;
    int hold_left;
    bit held_once;
    int stall_mode;
    int stretch_left;

    always #5 clk = ~clk;

    function automatic void clear_maze();
        for (int i = 0; i < CELL_COUNT; i++) begin
            parent_of[i] = i;
            open_mask[i] = '0;
        end
    endfunction

    function automatic int root_of(int start);
        int c;
        c = start;
        for (int steps = 0; steps < CELL_COUNT; steps++) begin
            if (parent_of[c] == c)
                break;
            c = parent_of[c];
        end
        return c;
    endfunction

    function automatic wall_report_t carve_and_report(maze_cmd_t c);
        wall_report_t r;
        int ew;
        int eh;
        int ci;
        int ni;
        int rc;
        int rn;
        bit in_grid;
        r = '0;
        ew = (grid_w > MAX_WIDTH) ? MAX_WIDTH : int'(grid_w);
        eh = (grid_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(grid_h);
        in_grid = (int'(c.x) < ew) && (int'(c.y) < eh);
        ci = int'(c.y) * MAX_WIDTH + int'(c.x);
        case (c.func)
            FUNC_CARVE: begin
                if (!in_grid || (c.west ? c.x == 0 : c.y == 0)) begin
                    r.bad = 1'b1;
                end
                else begin
                    ni = c.west ? ci - 1 : ci - MAX_WIDTH;
                    rc = root_of(ci);
                    rn = root_of(ni);
                    if (rc != rn) begin
                        parent_of[rn] = ci;
                        open_mask[ci] = open_mask[ci] | (c.west ? WALL_W : WALL_N);
                        open_mask[ni] = open_mask[ni] | (c.west ? WALL_E : WALL_S);
                        r.carved = 1'b1;
                    end
                    r.cell_walls = ~open_mask[ci];
                    r.nbr_walls = ~open_mask[ni];
                end
            end
            FUNC_READ: begin
                if (!in_grid)
                    r.bad = 1'b1;
                else
                    r.cell_walls = ~open_mask[ci];
            end
            FUNC_CLEAR: begin
                clear_maze();
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic void add_cmd(logic [1:0] f, int x, int y, bit w);
        maze_cmd_t c;
        c.func = f;
        c.x = COORD_W'(x);
        c.y = COORD_W'(y);
        c.west = w;
        cmd_backlog.insert(cmd_backlog.size(), c);
    endfunction

    // mostly in-grid carves, some reads, then noise over the whole field range
    function automatic maze_cmd_t random_cmd(int ew, int eh);
        maze_cmd_t c;
        int pick;
        pick = $urandom_range(0, 99);
        c.west = 1'($urandom_range(0, 1));
        c.x = COORD_W'($urandom_range(0, 31));
        c.y = COORD_W'($urandom_range(0, 31));
        if (pick < 88 && ew > 0 && eh > 0) begin
            c.x = COORD_W'($urandom_range(0, ew - 1));
            c.y = COORD_W'($urandom_range(0, eh - 1));
        end
        if (pick < 78)
            c.func = FUNC_CARVE;
        else if (pick < 88)
            c.func = FUNC_READ;
        else if (pick < 95)
            c.func = $urandom_range(0, 1) ? FUNC_CARVE : FUNC_READ;
        else if (pick < 98)
            c.func = FUNC_UNUSED;
        else
            c.func = FUNC_CLEAR;
        return c;
    endfunction

    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || report_queue.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(int w, int h, int count, bit clear_first);
        int ew;
        int eh;
        wait_idle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_GRID_WIDTH;
        cfg_data <= CFG_W'(w);
        @(negedge clk);
        cfg_index <= REG_GRID_HEIGHT;
        cfg_data <= CFG_W'(h);
        @(negedge clk);
        cfg_we <= 1'b0;
        ew = (w > MAX_WIDTH) ? MAX_WIDTH : w;
        eh = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
        if (clear_first)
            add_cmd(FUNC_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31), 1'b0);
        for (int i = 0; i < count; i++)
            cmd_backlog.insert(cmd_backlog.size(), random_cmd(ew, eh));
    endtask

    // sender: bursts and gaps, holds the item until the transfer
    always @(negedge clk) begin
        logic nxt_push;
        if (rst_n) begin
            if (in_accepted) begin
                void'(cmd_backlog.pop_front());
                if (burst_left > 0)
                    burst_left--;
            end
            if (!(push && !in_accepted)) begin
                nxt_push = 1'b0;
                if (burst_left == 0) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end
                    else begin
                        burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                if (burst_left > 0 && cmd_backlog.size() > 0) begin
                    nxt_push = 1'b1;
                    func <= cmd_backlog[0].func;
                    cell_x <= cmd_backlog[0].x;
                    cell_y <= cmd_backlog[0].y;
                    toward_west <= cmd_backlog[0].west;
                end
                push <= nxt_push;
            end
        end
    end

    // receiver: random stall stretches plus one long hold to back the block up
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (!held_once && results_seen >= HOLD_AFTER) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
                pop <= 1'b0;
            end
            else begin
                if (stretch_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    stretch_left = $urandom_range(8, 60);
                end
                stretch_left--;
                case (stall_mode)
                    0: pop <= 1'b1;
                    1: pop <= 1'($urandom_range(0, 1));
                    2: pop <= ($urandom_range(0, 3) == 0);
                    default: pop <= (stretch_left % 5 != 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        wall_report_t want;
        maze_cmd_t c;
        if (rst_n) begin
            if (pop && !empty) begin
                results_seen++;
                if (report_queue.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTED)
                        $display("unexpected result transfer at %0t", $realtime);
                end
                else begin
                    want = report_queue.pop_front();
                    if (carved !== want.carved || bad_edge !== want.bad ||
                        cell_walls !== want.cell_walls ||
                        neighbour_walls !== want.nbr_walls) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTED)
                            $display("result %0d: carved %b/%b bad %b/%b cell %h/%h nbr %h/%h",
                                     results_seen, want.carved, carved, want.bad, bad_edge,
                                     want.cell_walls, cell_walls, want.nbr_walls,
                                     neighbour_walls);
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_index == REG_GRID_WIDTH)
                    grid_w = cfg_data;
                else
                    grid_h = cfg_data;
            end
            if (push && !full) begin
                c.func = func;
                c.x = cell_x;
                c.y = cell_y;
                c.west = toward_west;
                report_queue.insert(report_queue.size(), carve_and_report(c));
            end
            in_accepted <= push && !full;
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_GRID_WIDTH;
        cfg_data = '0;
        push = 1'b0;
        func = FUNC_CARVE;
        cell_x = '0;
        cell_y = '0;
        toward_west = 1'b0;
        pop = 1'b0;
        grid_w = 6'd32;
        grid_h = 6'd32;
        clear_maze();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // edges on the border, joins, repeats, reads, unused code and clear
        add_cmd(FUNC_CARVE, 0, 0, 1'b0);
        add_cmd(FUNC_CARVE, 0, 7, 1'b1);
        add_cmd(FUNC_CARVE, 5, 0, 1'b1);
        add_cmd(FUNC_CARVE, 1, 1, 1'b1);
        add_cmd(FUNC_CARVE, 1, 1, 1'b0);
        add_cmd(FUNC_CARVE, 0, 1, 1'b0);
        add_cmd(FUNC_CARVE, 1, 0, 1'b1);
        add_cmd(FUNC_CARVE, 31, 31, 1'b0);
        add_cmd(FUNC_CARVE, 31, 31, 1'b1);
        add_cmd(FUNC_CARVE, 31, 31, 1'b1);
        add_cmd(FUNC_READ, 31, 31, 1'b1);
        add_cmd(FUNC_READ, 0, 0, 1'b0);
        add_cmd(FUNC_READ, 31, 0, 1'b1);
        add_cmd(FUNC_UNUSED, 31, 31, 1'b1);
        add_cmd(FUNC_UNUSED, 0, 0, 1'b0);
        add_cmd(FUNC_CLEAR, 31, 31, 1'b1);
        add_cmd(FUNC_READ, 1, 1, 1'b0);
        add_cmd(FUNC_CARVE, 31, 30, 1'b0);
        // neighbour root hangs under the cell itself, not under its root
        add_cmd(FUNC_CARVE, 2, 2, 1'b1);
        add_cmd(FUNC_CARVE, 3, 2, 1'b1);
        add_cmd(FUNC_CARVE, 3, 3, 1'b0);
        add_cmd(FUNC_CARVE, 1, 3, 1'b0);
        add_cmd(FUNC_CARVE, 2, 3, 1'b1);
        add_cmd(FUNC_CARVE, 3, 3, 1'b1);
        add_cmd(FUNC_READ, 2, 3, 1'b0);
        for (int i = 0; i < 350; i++)
            cmd_backlog.insert(cmd_backlog.size(), random_cmd(32, 32));

        run_phase(5, 4, 150, 1'b1);
        run_phase(0, 9, 40, 1'b0);
        run_phase(63, 33, 200, 1'b0);
        run_phase(1, 32, 100, 1'b1);
        run_phase(32, 1, 100, 1'b0);
        run_phase(1, 1, 30, 1'b0);
        run_phase(2, 2, 80, 1'b1);
        run_phase(17, 0, 30, 1'b0);
        run_phase(32, 32, 270, 1'b1);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && report_queue.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/kmuf_pkg.sv
hdl/kmuf_ram.sv
hdl/kmuf_queue.sv
hdl/kmuf_front.sv
hdl/kmuf_back.sv
hdl/kruskal_maze_union_find.sv
bench/tb_kruskal_maze_union_find.sv
